[rtl/binary_trie_min_xor_lookup_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the binary trie minimum-XOR lookup unit.
// Each macro expands to one labeled concurrent assertion clocked by clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_MIN_XOR_LOOKUP_UNIT_ASSERT_SVH
`define BINARY_TRIE_MIN_XOR_LOOKUP_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTMX_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTMX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/btmx_pkg.sv]
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared codes, widths and controller/datapath interface types for the
// binary trie minimum-XOR lookup unit.
// ----------------------------------------------------------------------------
package btmx_pkg;

	localparam int WORD_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int POS_OUT_W = 10;

	typedef logic [STATUS_W-1:0] btmx_status_t;

	localparam btmx_status_t ST_OK    = 2'd0;
	localparam btmx_status_t ST_EMPTY = 2'd1;
	localparam btmx_status_t ST_FULL  = 2'd2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic         load;
		logic         walk;
		logic         link;
		logic         build;
		logic         commit;
		logic         pos_cap;
		logic         push;
		btmx_status_t code;
	} btmx_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_query;
		logic root_empty;
		logic count_full;
		logic walk_miss;
		logic lvl_zero;
		logic cap_ok;
	} btmx_flags_t;

endpackage

[rtl/btmx_ram.sv]
// ----------------------------------------------------------------------------
// btmx_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module btmx_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/btmx_ctrl.sv]
// ----------------------------------------------------------------------------
// btmx_ctrl
// Controller: sequences one request word through load, trie walk, node
// allocation and result delivery, and owns both handshakes.
// ----------------------------------------------------------------------------
module btmx_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  btmx_pkg::btmx_flags_t flags,
	output btmx_pkg::btmx_cmd_t   cmd
);
	import btmx_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_LINK  = 3'd4;
	localparam logic [2:0] S_BUILD = 3'd5;
	localparam logic [2:0] S_POS   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]   state_q, state_n;
	btmx_status_t code_q, code_n;
	logic         rsp_valid_q;

	always_comb begin
		state_n     = state_q;
		code_n      = code_q;
		cmd         = '0;
		cmd.code    = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_n  = S_START;
				end
			end
			S_START: begin
				if (flags.is_query) begin
					if (flags.root_empty) begin
						code_n  = ST_EMPTY;
						state_n = S_DONE;
					end else begin
						state_n = S_WALK;
					end
				end else if (flags.count_full) begin
					code_n  = ST_FULL;
					state_n = S_DONE;
				end else begin
					state_n = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (!flags.is_query && flags.walk_miss) begin
					state_n = S_CHECK;
				end else if (flags.lvl_zero) begin
					if (flags.is_query) begin
						state_n = S_POS;
					end else begin
						// The word is already stored: it only takes a position.
						cmd.commit = 1'b1;
						code_n     = ST_OK;
						state_n    = S_DONE;
					end
				end
			end
			S_CHECK: begin
				if (flags.cap_ok) begin
					state_n = S_LINK;
				end else begin
					code_n  = ST_FULL;
					state_n = S_DONE;
				end
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_n  = S_BUILD;
			end
			S_BUILD: begin
				cmd.build = 1'b1;
				if (flags.lvl_zero) begin
					cmd.commit = 1'b1;
					code_n     = ST_OK;
					state_n    = S_DONE;
				end
			end
			S_POS: begin
				cmd.pos_cap = 1'b1;
				code_n      = ST_OK;
				state_n     = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.push = 1'b1;
					state_n  = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			code_q  <= code_n;
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

[rtl/btmx_dp.sv]
// ----------------------------------------------------------------------------
// btmx_dp
// Datapath: running key, trie root links, node and leaf-position memories,
// allocation pointer, insert counter and the result registers.
// ----------------------------------------------------------------------------
module btmx_dp #(
	parameter int KEY_BITS   = 32,
	parameter int NODE_COUNT = 32768,
	parameter int MAX_ITEMS  = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  btmx_pkg::btmx_cmd_t                  cmd,
	output btmx_pkg::btmx_flags_t                flags,
	input  logic                                 req_type,
	input  logic [btmx_pkg::WORD_W-1:0]          data_word,
	output logic [btmx_pkg::STATUS_W-1:0]        status,
	output logic [btmx_pkg::WORD_W-1:0]          match_word,
	output logic [btmx_pkg::POS_OUT_W-1:0]       match_position
);
	import btmx_pkg::*;

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int LINK_W = 2 * NODE_W;
	localparam int LVL_W  = $clog2(KEY_BITS);
	localparam int POS_W  = $clog2(MAX_ITEMS);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int NF_W   = NODE_W + 1;
	localparam int SUM_W  = NODE_W + 2;
	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(KEY_BITS - 1);

	// Persistent state
	logic [KEY_BITS-1:0] running_q;
	logic [LINK_W-1:0]   root_q;
	logic [NF_W-1:0]     nf_q;
	logic [CNT_W-1:0]    cnt_q;

	// Per-word working registers
	logic [KEY_BITS-1:0] key_q, found_q;
	logic                is_query_q, at_root_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [NODE_W-1:0]   node_q;
	logic [LINK_W-1:0]   par_links_q;
	logic [POS_W-1:0]    pos_q;

	// Result registers
	btmx_status_t        status_q;
	logic [WORD_W-1:0]   word_q;
	logic [POS_OUT_W-1:0] mpos_q;

	logic [KEY_BITS+WORD_W-1:0]   word_in_ext;
	logic [KEY_BITS-1:0]          word_in;
	logic [WORD_W+KEY_BITS-1:0]   found_ext;
	logic [POS_OUT_W+POS_W-1:0]   pos_ext;

	logic [LINK_W-1:0] node_rdata, cur_links, build_links, link_new, node_wdata;
	logic [NODE_W-1:0] child0, child1, c_pref, c_next, nf_idx, nf_p1, node_waddr;
	logic [POS_W-1:0]  leaf_rdata;
	logic [LVL_W-1:0]  lvl_m1;
	logic [SUM_W-1:0]  need_sum;
	logic              kb, miss, bsel, node_we, leaf_we, res_ok;

	assign word_in_ext = {{KEY_BITS{1'b0}}, data_word};
	assign word_in     = word_in_ext[KEY_BITS-1:0];

	// One trie level per cycle: the child chosen now addresses the next read.
	assign cur_links = at_root_q ? root_q : node_rdata;
	assign child0    = cur_links[NODE_W-1:0];
	assign child1    = cur_links[LINK_W-1:NODE_W];
	assign kb        = key_q[lvl_q];
	assign c_pref    = kb ? child1 : child0;
	assign miss      = (c_pref == '0);
	assign bsel      = (is_query_q && miss) ? ~kb : kb;
	assign c_next    = bsel ? child1 : child0;
	assign lvl_m1    = lvl_q - LVL_W'(1);

	assign nf_idx = nf_q[NODE_W-1:0];
	assign nf_p1  = nf_idx + NODE_W'(1);

	// A new inner node points at the node allocated right after it.
	always_comb begin
		if (lvl_q == '0) begin
			build_links = '0;
		end else if (key_q[lvl_m1]) begin
			build_links = {nf_p1, NODE_W'(0)};
		end else begin
			build_links = {NODE_W'(0), nf_p1};
		end
	end

	assign link_new = kb ? {nf_idx, par_links_q[NODE_W-1:0]}
	                     : {par_links_q[LINK_W-1:NODE_W], nf_idx};

	assign need_sum = SUM_W'(nf_q) + SUM_W'(lvl_q) + SUM_W'(1);

	assign node_we    = (cmd.link && !at_root_q) || cmd.build;
	assign node_waddr = cmd.build ? nf_idx : node_q;
	assign node_wdata = cmd.build ? build_links : link_new;
	assign leaf_we    = cmd.build && (lvl_q == '0);

	btmx_ram #(
		.WIDTH (LINK_W),
		.DEPTH (NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (c_next),
		.rdata (node_rdata)
	);

	btmx_ram #(
		.WIDTH (POS_W),
		.DEPTH (NODE_COUNT)
	) u_leaf_ram (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (nf_idx),
		.wdata (cnt_q[POS_W-1:0]),
		.raddr (c_next),
		.rdata (leaf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			root_q    <= '0;
			nf_q      <= NF_W'(1);
			cnt_q     <= '0;
		end else begin
			if (cmd.load && (req_type == REQ_QUERY)) begin
				running_q <= running_q ^ word_in;
			end
			if (cmd.link && at_root_q) begin
				root_q <= link_new;
			end
			if (cmd.build) begin
				nf_q <= nf_q + NF_W'(1);
			end
			if (cmd.commit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	assign found_ext = {{WORD_W{1'b0}}, found_q};
	assign pos_ext   = {{POS_OUT_W{1'b0}}, pos_q};
	assign res_ok    = (cmd.code == ST_OK) && is_query_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_query_q <= req_type;
			key_q      <= (req_type == REQ_QUERY) ? (running_q ^ word_in) : word_in;
			at_root_q  <= 1'b1;
			lvl_q      <= LVL_TOP;
		end
		if (cmd.walk) begin
			found_q[lvl_q] <= bsel;
			if (is_query_q || !miss) begin
				node_q    <= c_next;
				at_root_q <= 1'b0;
				lvl_q     <= lvl_m1;
			end else begin
				// Insert leaves the walk here; keep the parent for the link write.
				par_links_q <= cur_links;
			end
		end
		if (cmd.build) begin
			lvl_q <= lvl_m1;
		end
		if (cmd.pos_cap) begin
			pos_q <= leaf_rdata;
		end
		if (cmd.push) begin
			status_q <= cmd.code;
			word_q   <= res_ok ? found_ext[WORD_W-1:0] : '0;
			mpos_q   <= res_ok ? pos_ext[POS_OUT_W-1:0] : '0;
		end
	end

	assign flags.is_query   = is_query_q;
	assign flags.root_empty = (root_q == '0);
	assign flags.count_full = (cnt_q >= CNT_W'(MAX_ITEMS));
	assign flags.walk_miss  = miss;
	assign flags.lvl_zero   = (lvl_q == '0);
	assign flags.cap_ok     = (need_sum <= SUM_W'(NODE_COUNT));

	assign status         = status_q;
	assign match_word     = word_q;
	assign match_position = mpos_q;

endmodule

[rtl/binary_trie_min_xor_lookup_unit.sv]
// ----------------------------------------------------------------------------
// Binary trie minimum-XOR lookup unit
// Stores words in a binary trie and answers which stored word has the
// smallest XOR against a running key, with the word's first position.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_stall with req_type and data_word; one
// result word per request leaves on rsp_valid/rsp_stall with status,
// match_word and match_position.
// An insert (req_type 0) adds data_word with the next position number; a
// query (req_type 1) XORs data_word into the running key and walks the trie.
// One request is in work at a time; req_stall is high from acceptance until
// its result has been moved into the output register.
// The walk does one node memory read per trie level.
// The output register holds a result while rsp_stall is high; the next
// request is still accepted and worked on, and waits only to be delivered.
// Reset empties the trie, clears the running key and the position count,
// and needs no clearing pass over the node memories.
// ----------------------------------------------------------------------------
module binary_trie_min_xor_lookup_unit #(
	parameter int KEY_BITS   = 32,
	parameter int NODE_COUNT = 32768,
	parameter int MAX_ITEMS  = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            req_type,
	input  logic [btmx_pkg::WORD_W-1:0]     data_word,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [btmx_pkg::STATUS_W-1:0]   status,
	output logic [btmx_pkg::WORD_W-1:0]     match_word,
	output logic [btmx_pkg::POS_OUT_W-1:0]  match_position
);
	import btmx_pkg::*;

	btmx_cmd_t   cmd;
	btmx_flags_t flags;

	btmx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	btmx_dp #(
		.KEY_BITS   (KEY_BITS),
		.NODE_COUNT (NODE_COUNT),
		.MAX_ITEMS  (MAX_ITEMS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.flags          (flags),
		.req_type       (req_type),
		.data_word      (data_word),
		.status         (status),
		.match_word     (match_word),
		.match_position (match_position)
	);

endmodule

[rtl/btmx_checker.sv]
// ----------------------------------------------------------------------------
// btmx_checker
// Port-level checks on the lookup unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "binary_trie_min_xor_lookup_unit_assert.svh"

module btmx_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_stall,
	input logic                            rsp_valid,
	input logic                            rsp_stall,
	input logic [btmx_pkg::STATUS_W-1:0]   status,
	input logic [btmx_pkg::WORD_W-1:0]     match_word,
	input logic [btmx_pkg::POS_OUT_W-1:0]  match_position
);
	import btmx_pkg::*;

	// A stalled result word stays offered.
	`BTMX_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result word dropped while stalled")

	// Only one request is in work: an accepted word closes the request side.
	`BTMX_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request accepted while busy")

	`BTMX_ASSERT_SAME(a_status_code, rsp_valid, (status == ST_OK) || (status == ST_EMPTY) || (status == ST_FULL), "undefined status code")

	// Empty and full results carry no match.
	`BTMX_ASSERT_SAME(a_err_no_match, rsp_valid && (status != ST_OK), (match_word == '0) && (match_position == '0), "error result carries a match")

endmodule

bind binary_trie_min_xor_lookup_unit btmx_checker u_btmx_checker (.*);

[sim/binary_trie_min_xor_lookup_unit_tb.sv]
// ----------------------------------------------------------------------------
// Binary trie minimum-XOR lookup unit testbench
// Sends insert and query words through the valid/stall request channel and
// checks every response word against a trie kept inside the testbench. A
// short directed sequence covers the empty trie, the extreme words and a
// duplicate insert. Random traffic follows, and then the position space is
// filled so that later inserts must report a full store. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module binary_trie_min_xor_lookup_unit_tb;
	import btmx_pkg::*;

	localparam int KEY_BITS    = 32;
	localparam int NODE_COUNT  = 32768;
	localparam int MAX_ITEMS   = 1024;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		btmx_status_t           st;
		logic [WORD_W-1:0]      word;
		logic [POS_OUT_W-1:0]   pos;
	} trie_result_t;

	class trie_xor_scoreboard;
		int unsigned      child_idx[NODE_COUNT][2];
		int unsigned      first_pos[NODE_COUNT];
		int unsigned      free_node = 1;
		int unsigned      insert_cnt = 0;
		logic [31:0]      run_key = '0;
		logic [31:0]      known_words[$];
		trie_result_t     pending_results[$];
		int               errors = 0;

		function trie_result_t insert_word(logic [31:0] w);
			int unsigned node;
			int unsigned c;
			int unsigned needed;
			trie_result_t r;
			r = '{st: ST_OK, word: '0, pos: '0};
			if (insert_cnt >= MAX_ITEMS) begin
				r.st = ST_FULL;
				return r;
			end
			node = 0;
			needed = 0;
			for (int i = KEY_BITS - 1; i >= 0; i--) begin
				c = child_idx[node][w[i]];
				if (c == 0) begin
					needed = i + 1;
					break;
				end
				node = c;
			end
			if (needed > 0 && free_node + needed > NODE_COUNT) begin
				r.st = ST_FULL;
				return r;
			end
			node = 0;
			for (int i = KEY_BITS - 1; i >= 0; i--) begin
				c = child_idx[node][w[i]];
				if (c == 0) begin
					c = free_node++;
					child_idx[c][0] = 0;
					child_idx[c][1] = 0;
					first_pos[c] = insert_cnt;
					child_idx[node][w[i]] = c;
				end
				node = c;
			end
			// A duplicate keeps the leaf's earlier position but still uses one up.
			if (needed > 0)
				known_words.push_back(w);
			insert_cnt++;
			return r;
		endfunction

		function trie_result_t lookup_nearest(logic [31:0] w);
			int unsigned node;
			int unsigned c;
			logic b;
			trie_result_t r;
			r = '{st: ST_OK, word: '0, pos: '0};
			run_key = run_key ^ w;
			if (child_idx[0][0] == 0 && child_idx[0][1] == 0) begin
				r.st = ST_EMPTY;
				return r;
			end
			node = 0;
			for (int i = KEY_BITS - 1; i >= 0; i--) begin
				b = run_key[i];
				c = child_idx[node][b];
				if (c == 0) begin
					b = ~b;
					c = child_idx[node][b];
				end
				if (c == 0)
					break;
				r.word[i] = b;
				node = c;
			end
			r.pos = first_pos[node][POS_OUT_W-1:0];
			return r;
		endfunction

		function void note_request(logic t, logic [31:0] w);
			if (t == REQ_QUERY)
				pending_results.push_back(lookup_nearest(w));
			else
				pending_results.push_back(insert_word(w));
		endfunction

		function void check_response(logic [STATUS_W-1:0] st, logic [WORD_W-1:0] w,
				logic [POS_OUT_W-1:0] p);
			trie_result_t e;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected response status=%h word=%h pos=%h", $time, st, w, p);
				return;
			end
			e = pending_results.pop_front();
			if (st !== e.st) begin
				errors++;
				$display("%0t: status expected %h actual %h", $time, e.st, st);
			end
			if (w !== e.word) begin
				errors++;
				$display("%0t: match_word expected %h actual %h", $time, e.word, w);
			end
			if (p !== e.pos) begin
				errors++;
				$display("%0t: match_position expected %h actual %h", $time, e.pos, p);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic                  req_type = REQ_INSERT;
	logic [WORD_W-1:0]     data_word = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [WORD_W-1:0]     match_word;
	logic [POS_OUT_W-1:0]  match_position;

	trie_xor_scoreboard sb;
	bit                 calm = 1'b0;
	int                 cycle_cnt = 0;

	binary_trie_min_xor_lookup_unit #(
		.KEY_BITS  (KEY_BITS),
		.NODE_COUNT(NODE_COUNT),
		.MAX_ITEMS (MAX_ITEMS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.data_word     (data_word),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.match_word    (match_word),
		.match_position(match_position)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int idle_len(int short_pct, int mid_pct, int long_max);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < short_pct)
			return 0;
		if (r < mid_pct)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, long_max);
	endfunction

	// Called at a rising edge; returns at the edge where the word was taken, or after the idle gap that follows it.
	task automatic send_request(logic t, logic [31:0] w);
		int gap;
		bit taken;
		req_valid <= 1'b1;
		req_type  <= t;
		data_word <= w;
		// The stall seen at the falling edge before a rising edge is the one that rising edge acts on.
		do begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end while (!taken);
		sb.note_request(t, w);
		gap = idle_len(55, 88, 80);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	function automatic logic [31:0] pick_stored();
		return sb.known_words[$urandom_range(0, sb.known_words.size() - 1)];
	endfunction

	// Aim most queries at a stored word, sometimes a few bits off, so the
	// walk has to fall back to the other branch deep in the trie.
	function automatic logic [31:0] query_word();
		int r;
		logic [31:0] flip;
		r = $urandom_range(0, 9);
		if (sb.known_words.size() == 0 || r < 3)
			return $urandom();
		if (r < 6)
			flip = '0;
		else if (r < 8)
			flip = $urandom() & ((32'd1 << $urandom_range(1, 12)) - 32'd1);
		else
			flip = 32'd1 << $urandom_range(0, 31);
		return sb.run_key ^ pick_stored() ^ flip;
	endfunction

	function automatic logic [31:0] insert_data();
		int r;
		r = $urandom_range(0, 19);
		if (sb.known_words.size() == 0 || r < 10)
			return $urandom();
		if (r < 11)
			return $urandom_range(0, 255);
		if (r < 14)
			return pick_stored();
		if (r < 17)
			return pick_stored() ^ (32'd1 << $urandom_range(0, 31));
		return pick_stored() ^ ($urandom() & 32'h0000_00ff);
	endfunction

	task automatic send_random(int query_pct);
		if ($urandom_range(0, 99) < query_pct)
			send_request(REQ_QUERY, query_word());
		else
			send_request(REQ_INSERT, insert_data());
	endtask

	task automatic run_directed();
		logic        dir_type[20] = '{
			REQ_QUERY,  REQ_QUERY,  REQ_INSERT, REQ_INSERT, REQ_QUERY,
			REQ_QUERY,  REQ_INSERT, REQ_QUERY,  REQ_INSERT, REQ_INSERT,
			REQ_QUERY,  REQ_QUERY,  REQ_INSERT, REQ_INSERT, REQ_INSERT,
			REQ_QUERY,  REQ_QUERY,  REQ_INSERT, REQ_QUERY,  REQ_QUERY};
		logic [31:0] dir_word[20] = '{
			32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000,
			32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'hffff_ffff, 32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555,
			32'hd555_5555, 32'hffff_ffff, 32'haaaa_aaaa, 32'h8000_0001, 32'h7fff_fffe};
		for (int i = 0; i < 20; i++)
			send_request(dir_type[i], dir_word[i]);
	endtask

	// Response side: stall at random, check each word taken. The word is
	// checked at the falling edge before the edge that takes it, when it is stable.
	initial begin
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_valid && !rsp_stall)
				sb.check_response(status, match_word, match_position);
			@(posedge clk);
			if (hold > 0)
				hold--;
			else
				hold = idle_len(65, 92, 60);
			rsp_stall <= (hold > 0);
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		sb = new;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain_results();

		for (int i = 0; i < 1500; i++) begin
			calm = (i >= 500 && i < 700);
			send_random(50);
		end
		calm = 1'b0;
		drain_results();

		// Use up the remaining positions, then keep inserting into a full store.
		while (sb.insert_cnt < MAX_ITEMS)
			send_random(20);
		for (int i = 0; i < 120; i++)
			send_random(50);

		drain_results();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors, %0d responses missing", sb.errors,
				sb.pending_results.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/btmx_pkg.sv
rtl/btmx_ram.sv
rtl/btmx_ctrl.sv
rtl/btmx_dp.sv
rtl/binary_trie_min_xor_lookup_unit.sv
rtl/btmx_checker.sv
sim/binary_trie_min_xor_lookup_unit_tb.sv
